// File: rtl/blr_pkg.sv
// Shared constants and types for the line rasterizer.
package blr_pkg;

	localparam int CFG_W    = 12;
	localparam int COLOR_W  = 32;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] frame_width;
		logic [CFG_W-1:0] frame_height;
	} blr_cfg_t;

endpackage

// File: rtl/blr_regs.sv
// APB register file holding the clipping frame size.
module blr_regs
	import blr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output blr_cfg_t          cfg
);

	blr_cfg_t cfg_q;
	logic     wr_en;
	logic     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_q.frame_height);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/blr_setup.sv
// Line setup: octant choice, endpoint ordering, decision term and increments.
module blr_setup
	import blr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  steep,
	output logic                  step_sign,
	output logic                  active,
	output logic [COORD_BITS-1:0] major_pos,
	output logic [COORD_BITS-1:0] minor_pos,
	output logic [COORD_BITS-1:0] major_end,
	output logic [COORD_BITS+3:0] err_init,
	output logic [COORD_BITS+1:0] inc_straight,
	output logic [COORD_BITS+2:0] inc_diag
);

	localparam int C  = COORD_BITS;
	localparam int DW = COORD_BITS + 1;

	logic [DW-1:0] dx, dy, ax, ay;
	logic [C-1:0]  ma, na, mb, nb;
	logic [C-1:0]  m0, n0, m1, n1;
	logic          swap;
	logic [DW-1:0] dmaj, dmin, dmin_mag;
	logic [C-1:0]  dmaj_mag, dmin_abs;

	always_comb begin
		dx = {x_end[C-1], x_end} - {x_start[C-1], x_start};
		dy = {y_end[C-1], y_end} - {y_start[C-1], y_start};
		ax = dx[DW-1] ? (~dx + DW'(1)) : dx;
		ay = dy[DW-1] ? (~dy + DW'(1)) : dy;
		steep = !(ay < ax);

		if (steep) begin
			m0 = y_start; n0 = x_start; m1 = y_end; n1 = x_end;
		end else begin
			m0 = x_start; n0 = y_start; m1 = x_end; n1 = y_end;
		end
		swap = $signed(m0) > $signed(m1);
		ma = swap ? m1 : m0;
		na = swap ? n1 : n0;
		mb = swap ? m0 : m1;
		nb = swap ? n0 : n1;

		dmaj      = {mb[C-1], mb} - {ma[C-1], ma};
		dmin      = {nb[C-1], nb} - {na[C-1], na};
		step_sign = dmin[DW-1];
		dmin_mag  = dmin[DW-1] ? (~dmin + DW'(1)) : dmin;
		dmin_abs  = dmin_mag[C-1:0];
		dmaj_mag  = dmaj[C-1:0];

		inc_straight = {1'b0, dmin_abs, 1'b0};
		inc_diag     = {1'b0, inc_straight} - {2'b00, dmaj_mag, 1'b0};
		err_init     = {3'b000, dmin_abs, 1'b0} - {4'b0000, dmaj_mag};

		major_pos = ma;
		minor_pos = na;
		major_end = mb;
		active    = $signed(ma) < $signed(mb);
	end

endmodule

// File: rtl/bresenham_line_raster.sv
// Top level of the Bresenham line rasterizer: line state, pixel step and output register.
//
//   channel   dir  handshake           beat
//   in        in   in_valid/in_ready   op, endpoints, color
//   out       out  out_valid/out_ready pixel_x, pixel_y, pixel_color, visible, last
//   cfg       in   APB psel/penable    frame_width @0x0, frame_height @0x4
//
// One beat per clock while in_ready is high: a start beat sets up the line in the cycle
// it is taken, a tick beat steps the error term and loads the output register in that
// same cycle. A beat is taken whenever the output register is empty or being drained.
// Reset clears the line-active flag, the output valid and the frame size to 640x480.
module bresenham_line_raster
	import blr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_W-1:0]    color,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  visible,
	output logic                  last,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int C    = COORD_BITS;
	localparam int CMPW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

	blr_cfg_t cfg;

	logic          su_steep, su_sign, su_active;
	logic [C-1:0]  su_major, su_minor, su_end;
	logic [C+3:0]  su_err;
	logic [C+1:0]  su_inc_s;
	logic [C+2:0]  su_inc_d;

	logic          busy_q, steep_q, step_sign_q;
	logic [C-1:0]  major_pos_q, minor_pos_q, major_end_q;
	logic [C+3:0]  err_term_q;
	logic [C+1:0]  inc_straight_q;
	logic [C+2:0]  inc_diag_q;
	logic [COLOR_W-1:0] line_color_q;

	logic          out_valid_q, visible_q, last_q;
	logic [C-1:0]  pixel_x_q, pixel_y_q;
	logic [COLOR_W-1:0] pixel_color_q;

	logic          in_beat, do_start, do_tick;
	logic [C-1:0]  px, py;
	logic          fin, vis, err_le0;

	blr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	blr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.steep        (su_steep),
		.step_sign    (su_sign),
		.active       (su_active),
		.major_pos    (su_major),
		.minor_pos    (su_minor),
		.major_end    (su_end),
		.err_init     (su_err),
		.inc_straight (su_inc_s),
		.inc_diag     (su_inc_d)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign in_beat  = in_valid && in_ready;
	assign do_start = in_beat && (op == OP_START);
	assign do_tick  = in_beat && (op == OP_TICK) && busy_q;

	assign px      = steep_q ? minor_pos_q : major_pos_q;
	assign py      = steep_q ? major_pos_q : minor_pos_q;
	assign fin     = ({major_pos_q[C-1], major_pos_q} + (C+1)'(1)) ==
	                 {major_end_q[C-1], major_end_q};
	assign vis     = !px[C-1] && (CMPW'(px) < CMPW'(cfg.frame_width)) &&
	                 !py[C-1] && (CMPW'(py) < CMPW'(cfg.frame_height));
	assign err_le0 = err_term_q[C+3] || (err_term_q == '0);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (do_start) begin
			busy_q <= su_active;
		end else if (do_tick && fin) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			steep_q        <= su_steep;
			step_sign_q    <= su_sign;
			major_pos_q    <= su_major;
			minor_pos_q    <= su_minor;
			major_end_q    <= su_end;
			err_term_q     <= su_err;
			inc_straight_q <= su_inc_s;
			inc_diag_q     <= su_inc_d;
			line_color_q   <= color;
		end else if (do_tick) begin
			major_pos_q <= major_pos_q + C'(1);
			if (err_le0) begin
				err_term_q <= err_term_q + {2'b00, inc_straight_q};
			end else begin
				err_term_q  <= err_term_q + {inc_diag_q[C+2], inc_diag_q};
				minor_pos_q <= step_sign_q ? (minor_pos_q - C'(1)) : (minor_pos_q + C'(1));
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= do_tick;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			pixel_x_q     <= px;
			pixel_y_q     <= py;
			pixel_color_q <= line_color_q;
			visible_q     <= vis;
			last_q        <= fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign visible     = visible_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	a_busy_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ($signed(major_pos_q) < $signed(major_end_q)))
		else $error("active line with major position at or past its end");

	a_tick_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op == OP_TICK) && busy_q) |=> out_valid)
		else $error("tick on an active line gave no pixel");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op == OP_START)) |=> !out_valid)
		else $error("start beat produced a pixel");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(do_tick && fin) |=> (!busy_q || $past(do_start)))
		else $error("line still active after its last pixel");
`endif

endmodule
